// File: src/lsl_pkg.sv
// Shared types, codes and defaults for the LRU slot list with pins.
`default_nettype none
package lsl_pkg;

   localparam int DEF_NUM_SLOTS  = 256;
   localparam int DEF_ID_BITS    = 32;
   localparam int DEF_COUNT_BITS = 8;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_ALLOC  = 2'd0;
   localparam kind_type KIND_TOUCH  = 2'd1;
   localparam kind_type KIND_ADDREF = 2'd2;
   localparam kind_type KIND_DELREF = 2'd3;

   // commands from the controller to the datapath
   typedef struct packed {
      logic clr_step;   // write one reset entry, advance sweep index
      logic load;       // capture the incoming transaction
      logic rd_slot;    // read address: item slot (1) or oldest (0)
      logic rotate;     // move the oldest slot to the newest end
      logic grant;      // rotate, swap identifier, record the grant
      logic unlink;     // take the item slot out of the chain
      logic link;       // hang the item slot at the newest end
      logic cnt_write;  // apply add or remove reference
      logic finish;     // load the result into the output register
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic     clear_last;
      kind_type kind;
      logic     slot_ok;
      logic     is_newest;
      logic     cnt_zero;
      logic     free_zero;
      logic     out_free;
   } sts_type;

endpackage
`default_nettype wire

// File: src/lsl_ram.sv
// Generic single write, single read RAM with registered read data.
`default_nettype none
module lsl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port, read port returns the old contents on a collision
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// File: src/lsl_ctrl.sv
// Controller state machine for the LRU slot list with pins.
`default_nettype none
module lsl_ctrl
   import lsl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_DISPATCH = 3'd2;
   localparam logic [2:0] ST_WREAD    = 3'd3;
   localparam logic [2:0] ST_WEVAL    = 3'd4;
   localparam logic [2:0] ST_UNLINK   = 3'd5;
   localparam logic [2:0] ST_LINK     = 3'd6;
   localparam logic [2:0] ST_DONE     = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   // sequence one transaction at a time
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sts.kind == KIND_ALLOC) begin
               state_in = sts.free_zero ? ST_DONE : ST_WREAD;
            end else if (!sts.slot_ok) begin
               state_in = ST_DONE;
            end else if (sts.kind == KIND_TOUCH) begin
               cmd.rd_slot = 1'b1;
               state_in    = sts.is_newest ? ST_DONE : ST_UNLINK;
            end else begin
               cmd.rd_slot = 1'b1;
               state_in    = ST_LINK;
            end
         end
         ST_WREAD: begin
            state_in = ST_WEVAL;
         end
         ST_WEVAL: begin
            if (sts.cnt_zero) begin
               cmd.grant = 1'b1;
               state_in  = ST_DONE;
            end else begin
               cmd.rotate = 1'b1;
               state_in   = ST_WREAD;
            end
         end
         ST_UNLINK: begin
            cmd.rd_slot = 1'b1;
            cmd.unlink  = 1'b1;
            state_in    = ST_LINK;
         end
         ST_LINK: begin
            cmd.rd_slot = 1'b1;
            if (sts.kind == KIND_TOUCH) begin
               cmd.link = 1'b1;
            end else begin
               cmd.cnt_write = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // no transaction enters before the sweep ends
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("request taken during clearing sweep");

   // a grant leads straight to the done state
   assert property (@(posedge clock) disable iff (reset)
      cmd.grant |=> (state_ff == ST_DONE))
      else $error("grant not followed by result");

   // link, unlink or count write only for a valid slot
   assert property (@(posedge clock) disable iff (reset)
      (cmd.unlink || cmd.link || cmd.cnt_write) |-> sts.slot_ok)
      else $error("list update on out of range slot");

endmodule
`default_nettype wire

// File: src/lsl_dpath.sv
// Datapath for the LRU slot list: link, identifier and count memories.
`default_nettype none
module lsl_dpath
   import lsl_pkg::*;
#(
   parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
   parameter int ID_BITS    = DEF_ID_BITS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_slot,
   input  wire logic [31:0] req_new_id,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_granted,
   output logic [7:0]       rsp_out_slot,
   output logic [31:0]      rsp_evicted_id,
   output logic [8:0]       rsp_free_count
);

   localparam int SLOT_BITS = $clog2(NUM_SLOTS);
   localparam int FREE_BITS = $clog2(NUM_SLOTS + 1);
   localparam logic [SLOT_BITS-1:0]  LAST_SLOT = SLOT_BITS'(NUM_SLOTS - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // transaction and list registers
   kind_type              kind_ff;
   logic                  slot_ok_ff;
   logic [SLOT_BITS-1:0]  slot_ff;
   logic [ID_BITS-1:0]    nid_ff;
   logic [SLOT_BITS-1:0]  oldest_ff, oldest_in;
   logic [SLOT_BITS-1:0]  newest_ff, newest_in;
   logic [FREE_BITS-1:0]  free_ff, free_in;
   logic [SLOT_BITS-1:0]  clr_idx_ff;
   logic                  res_granted_ff;
   logic [7:0]            res_slot_ff;
   logic [31:0]           res_evicted_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_granted_ff;
   logic [7:0]            rsp_slot_ff;
   logic [31:0]           rsp_evicted_ff;
   logic [8:0]            rsp_free_ff;

   // memory ports
   logic [SLOT_BITS-1:0]  raddr;
   logic                  nx_we, pv_we, id_we, ct_we;
   logic [SLOT_BITS-1:0]  nx_waddr, pv_waddr, id_waddr, ct_waddr;
   logic [SLOT_BITS-1:0]  nx_wdata, pv_wdata;
   logic [ID_BITS-1:0]    id_wdata;
   logic [COUNT_BITS-1:0] ct_wdata;
   logic [SLOT_BITS-1:0]  nx_rdata, pv_rdata;
   logic [ID_BITS-1:0]    id_rdata;
   logic [COUNT_BITS-1:0] ct_rdata;

   assign raddr = cmd.rd_slot ? slot_ff : oldest_ff;

   // drive memory writes from the current command
   always_comb begin
      nx_we = 1'b0; nx_waddr = newest_ff; nx_wdata = oldest_ff;
      pv_we = 1'b0; pv_waddr = oldest_ff; pv_wdata = newest_ff;
      id_we = 1'b0; id_waddr = oldest_ff; id_wdata = nid_ff;
      ct_we = 1'b0; ct_waddr = slot_ff;   ct_wdata = ct_rdata;
      oldest_in = oldest_ff;
      newest_in = newest_ff;
      free_in   = free_ff;
      if (cmd.clr_step) begin
         nx_we = 1'b1; nx_waddr = clr_idx_ff;
         nx_wdata = (clr_idx_ff == LAST_SLOT) ? '0 : clr_idx_ff + 1'b1;
         pv_we = 1'b1; pv_waddr = clr_idx_ff;
         pv_wdata = (clr_idx_ff == '0) ? LAST_SLOT : clr_idx_ff - 1'b1;
         id_we = 1'b1; id_waddr = clr_idx_ff; id_wdata = '0;
         ct_we = 1'b1; ct_waddr = clr_idx_ff; ct_wdata = '0;
      end
      if (cmd.rotate || cmd.grant) begin
         nx_we     = 1'b1;
         pv_we     = 1'b1;
         oldest_in = nx_rdata;
         newest_in = oldest_ff;
         id_we     = cmd.grant;
      end
      if (cmd.unlink) begin
         if (slot_ff == oldest_ff) begin
            oldest_in = nx_rdata;
         end else begin
            nx_we = 1'b1; nx_waddr = pv_rdata; nx_wdata = nx_rdata;
            pv_we = 1'b1; pv_waddr = nx_rdata; pv_wdata = pv_rdata;
         end
      end
      if (cmd.link) begin
         nx_we = 1'b1; nx_waddr = newest_ff; nx_wdata = slot_ff;
         pv_we = 1'b1; pv_waddr = slot_ff;   pv_wdata = newest_ff;
         newest_in = slot_ff;
      end
      if (cmd.cnt_write) begin
         ct_we = 1'b1;
         if (kind_ff == KIND_ADDREF) begin
            if (ct_rdata != COUNT_MAX) begin
               ct_wdata = ct_rdata + 1'b1;
               if (ct_rdata == '0 && free_ff != '0) begin
                  free_in = free_ff - 1'b1;
               end
            end
         end else if (ct_rdata != '0) begin
            ct_wdata = ct_rdata - 1'b1;
            if (ct_rdata == COUNT_BITS'(1)) begin
               free_in = free_ff + 1'b1;
            end
         end
      end
   end

   lsl_ram #(.WIDTH(SLOT_BITS), .DEPTH(NUM_SLOTS)) u_next (
      .clock(clock), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
      .raddr(raddr), .rdata(nx_rdata));

   lsl_ram #(.WIDTH(SLOT_BITS), .DEPTH(NUM_SLOTS)) u_prev (
      .clock(clock), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
      .raddr(raddr), .rdata(pv_rdata));

   lsl_ram #(.WIDTH(ID_BITS), .DEPTH(NUM_SLOTS)) u_ident (
      .clock(clock), .we(id_we), .waddr(id_waddr), .wdata(id_wdata),
      .raddr(raddr), .rdata(id_rdata));

   lsl_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_SLOTS)) u_count (
      .clock(clock), .we(ct_we), .waddr(ct_waddr), .wdata(ct_wdata),
      .raddr(raddr), .rdata(ct_rdata));

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff    <= '0;
         newest_ff    <= LAST_SLOT;
         free_ff      <= FREE_BITS'(NUM_SLOTS);
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         oldest_ff <= oldest_in;
         newest_ff <= newest_in;
         free_ff   <= free_in;
         if (cmd.clr_step) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // capture transaction, track result, fill output register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff        <= req_kind;
         slot_ok_ff     <= (32'(req_slot) < 32'(NUM_SLOTS));
         slot_ff        <= SLOT_BITS'(req_slot);
         nid_ff         <= ID_BITS'(req_new_id);
         res_granted_ff <= 1'b0;
         res_slot_ff    <= (req_kind == KIND_ALLOC) ? 8'd0 : req_slot;
         res_evicted_ff <= '0;
      end
      if (cmd.grant) begin
         res_granted_ff <= 1'b1;
         res_slot_ff    <= 8'(oldest_ff);
         res_evicted_ff <= 32'(id_rdata);
      end
      if (cmd.finish) begin
         rsp_granted_ff <= res_granted_ff;
         rsp_slot_ff    <= res_slot_ff;
         rsp_evicted_ff <= res_evicted_ff;
         rsp_free_ff    <= 9'(free_ff);
      end
   end

   always_comb begin
      sts.clear_last = (clr_idx_ff == LAST_SLOT);
      sts.kind       = kind_ff;
      sts.slot_ok    = slot_ok_ff;
      sts.is_newest  = (slot_ff == newest_ff);
      sts.cnt_zero   = (ct_rdata == '0);
      sts.free_zero  = (free_ff == '0);
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted    = rsp_granted_ff;
   assign rsp_out_slot   = rsp_slot_ff;
   assign rsp_evicted_id = rsp_evicted_ff;
   assign rsp_free_count = rsp_free_ff;

   // free total never exceeds the slot count
   assert property (@(posedge clock) disable iff (reset)
      32'(free_ff) <= 32'(NUM_SLOTS))
      else $error("free total above slot count");

   // the two ends of the list never coincide
   assert property (@(posedge clock) disable iff (reset)
      oldest_ff != newest_ff)
      else $error("oldest and newest collapsed");

   // a granted slot carries no reference
   assert property (@(posedge clock) disable iff (reset)
      cmd.grant |-> (ct_rdata == '0))
      else $error("pinned slot granted");

   // a finished result is presented next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("result lost");

endmodule
`default_nettype wire

// File: src/lru_slot_list_with_pins.sv
// Top level: LRU order of cache slots with reference-count pins.
//
// Request channel (req_*): kind, slot and new_id, taken when req_valid is
// high and req_stall low. Response channel (rsp_*): one transaction per
// request carrying granted, out_slot, evicted_id and free_count.
// Requests are handled one at a time by a controller over linked-list
// memories (next, prev, identifier, count) with one read and one write port.
// Each transaction steps through the controller states after acceptance:
//   touch: dispatch, unlink, link, done; touch of the newest slot:
//   dispatch, done; add and remove reference: dispatch, link, done;
//   allocate: dispatch, then a read and an evaluation for each slot
//   on the walk, done; refused allocate or out of range slot: dispatch, done.
// The next request is taken in the cycle after a result is loaded, once the
// controller is back in the idle state. Each pinned slot passed on the
// allocate walk costs one memory read and one relink.
// After reset a sweep over every slot rebuilds the chain in slot order
// and clears identifiers and counts; req_stall stays high until it ends.
// A result waits in the output register while rsp_stall is high; the next
// request is still taken and completes up to the point of delivery.
`default_nettype none
module lru_slot_list_with_pins
   import lsl_pkg::*;
#(
   parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
   parameter int ID_BITS    = DEF_ID_BITS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_slot,
   input  wire logic [31:0] req_new_id,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_granted,
   output logic [7:0]       rsp_out_slot,
   output logic [31:0]      rsp_evicted_id,
   output logic [8:0]       rsp_free_count
);

   cmd_type cmd;
   sts_type sts;

   lsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lsl_dpath #(
      .NUM_SLOTS  (NUM_SLOTS),
      .ID_BITS    (ID_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_kind       (req_kind),
      .req_slot       (req_slot),
      .req_new_id     (req_new_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_granted    (rsp_granted),
      .rsp_out_slot   (rsp_out_slot),
      .rsp_evicted_id (rsp_evicted_id),
      .rsp_free_count (rsp_free_count)
   );

endmodule
`default_nettype wire
